// File: design/tsc_pkg.sv
`default_nettype none
package tsc_pkg;
	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int VALUE_BITS_DEF  = 19;
	localparam int WIN_DIV         = 25;
	// n / 25 == (n * 5243) >> 17 for every n up to 4096
	localparam int RECIP_MUL       = 5243;
	localparam int RECIP_SHIFT     = 17;

	localparam int CC_W  = 11;
	localparam int THR_W = 9;
	localparam int IDX_W = 10;
	localparam int ADDR_W = 3;

	localparam logic REG_COUNT  = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	localparam logic [CC_W-1:0]         COUNT_RESET  = 11'd1024;
	localparam logic signed [THR_W-1:0] THRESH_RESET = 9'sd10;
endpackage
`default_nettype wire

// File: design/tsc_if.sv
`default_nettype none
interface tsc_in_if #(parameter int VALUE_BITS = tsc_pkg::VALUE_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value_db;
	logic                         column_valid;
	modport source (output valid, value_db, column_valid, input ready);
	modport sink (input valid, value_db, column_valid, output ready);
endinterface

interface tsc_out_if #(parameter int VALUE_BITS = tsc_pkg::VALUE_BITS_DEF);
	logic                            valid;
	logic                            ready;
	logic [tsc_pkg::IDX_W-1:0]       column_index;
	logic signed [VALUE_BITS-1:0]    value_out;
	logic                            valid_out;
	logic                            clipped;
	logic                            last_column;
	modport source (output valid, column_index, value_out, valid_out, clipped, last_column,
		input ready);
	modport sink (input valid, column_index, value_out, valid_out, clipped, last_column,
		output ready);
endinterface
`default_nettype wire

// File: design/trace_spur_clipper.sv
`default_nettype none
// channel   dir  handshake          beat
// in_ch     in   valid/ready        value_db, column_valid
// out_ch    out  valid/ready        column_index, value_out, valid_out, clipped, last_column
// apb       in   psel/penable/pwrite column_count @0x0, spur_threshold_db @0x4
//
// A column's cost grows with W = count/25 (it is least when W is below 2), set by the
// single read port of the neighbour ring; a clipped column adds the time of the
// serial divider, which grows with VALUE_BITS and $clog2(MAX_COLUMNS/25+1).
// Results wait in an output register; a two-beat queue holds inputs.
// Reset clears counters and handshake state; the ring needs no clearing.
module trace_spur_clipper #(
	parameter int MAX_COLUMNS = tsc_pkg::MAX_COLUMNS_DEF,
	parameter int VALUE_BITS  = tsc_pkg::VALUE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	tsc_in_if.sink                           in_ch,
	tsc_out_if.source                        out_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tsc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	logic [tsc_pkg::CC_W-1:0]         count_q;
	logic signed [tsc_pkg::THR_W-1:0] thresh_q;
	logic                             wr_en;
	logic                             restart;
	logic                             q_full;
	logic                             q_avail;
	logic                             q_pop;
	logic [VALUE_BITS:0]              q_data;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign restart = wr_en && (paddr[2] == tsc_pkg::REG_COUNT);
	assign prdata  = (paddr[2] == tsc_pkg::REG_THRESH) ? 32'(unsigned'(thresh_q))
	                                                   : 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= tsc_pkg::COUNT_RESET;
			thresh_q <= tsc_pkg::THRESH_RESET;
		end else if (wr_en) begin
			if (paddr[2] == tsc_pkg::REG_COUNT) begin
				count_q <= pwdata[tsc_pkg::CC_W-1:0];
			end else begin
				thresh_q <= pwdata[tsc_pkg::THR_W-1:0];
			end
		end
	end

	assign in_ch.ready = !q_full;

	tsc_fifo #(.W(VALUE_BITS + 1)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_ch.valid && !q_full),
		.push_data ({in_ch.column_valid, in_ch.value_db}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_avail),
		.pop_data  (q_data)
	);

	tsc_back #(.MAX_COLUMNS(MAX_COLUMNS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_avail   (q_avail),
		.item_data    (q_data),
		.item_pop     (q_pop),
		.column_count (count_q),
		.threshold    (thresh_q),
		.restart      (restart),
		.out_ch       (out_ch)
	);
endmodule
`default_nettype wire

// File: design/tsc_fifo.sv
`default_nettype none
module tsc_fifo #(
	parameter int W = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              not_empty,
	output logic [W-1:0]      pop_data
);
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// File: design/tsc_div.sv
`default_nettype none
module tsc_div #(
	parameter int NW = 26,
	parameter int DW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);
	localparam int CW = $clog2(NW + 1);

	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dsr_q;
	logic [CW-1:0] step_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          take;

	assign rem_sh   = {rem_q[DW-1:0], quo_q[NW-1]};
	assign take     = (rem_sh >= {1'b0, dsr_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, dsr_q} : rem_sh;
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: design/tsc_back.sv
`default_nettype none
module tsc_back #(
	parameter int MAX_COLUMNS = tsc_pkg::MAX_COLUMNS_DEF,
	parameter int VALUE_BITS  = tsc_pkg::VALUE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_avail,
	input  wire logic [VALUE_BITS:0]             item_data,
	output logic                                 item_pop,
	input  wire logic [tsc_pkg::CC_W-1:0]        column_count,
	input  wire logic signed [tsc_pkg::THR_W-1:0] threshold,
	input  wire logic                            restart,
	tsc_out_if.source                            out_ch
);
	localparam int WMAX  = MAX_COLUMNS / tsc_pkg::WIN_DIV;
	localparam int DEPTH = 2 * WMAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(MAX_COLUMNS + 1);
	localparam int WW    = $clog2(WMAX + 1);
	localparam int CW    = WW + 1;
	localparam int SW    = VALUE_BITS + CW;
	localparam int DFW   = VALUE_BITS + 10;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_CTR   = 4'd2;
	localparam logic [3:0] S_LEFT  = 4'd3;
	localparam logic [3:0] S_RIGHT = 4'd4;
	localparam logic [3:0] S_LAST  = 4'd5;
	localparam logic [3:0] S_EVAL  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	localparam logic [1:0] TAG_NONE = 2'd0;
	localparam logic [1:0] TAG_CTR  = 2'd1;
	localparam logic [1:0] TAG_LEFT = 2'd2;
	localparam logic [1:0] TAG_RGHT = 2'd3;

	logic [VALUE_BITS:0] ring_q [DEPTH];
	logic [VALUE_BITS:0] rd_data_s1;
	logic [1:0]          tag_s1;

	logic [3:0]      state_q;
	logic [CNTW-1:0] rcv_q;
	logic [CNTW-1:0] rsv_q;
	logic [AW-1:0]   wslot_q;
	logic [AW-1:0]   rslot_q;
	logic [WW-1:0]   j_q;

	logic signed [VALUE_BITS-1:0] v_q;
	logic                         cv_q;
	logic signed [VALUE_BITS-1:0] lmin_q;
	logic signed [VALUE_BITS-1:0] rmin_q;
	logic                         lhas_q;
	logic                         rhas_q;
	logic signed [SW-1:0]         sum_q;
	logic [CW-1:0]                cnt_q;
	logic                         neg_q;
	logic                         clip_q;

	logic                         ov_q;
	logic [tsc_pkg::IDX_W-1:0]    o_idx_q;
	logic signed [VALUE_BITS-1:0] o_val_q;
	logic                         o_vld_q;
	logic                         o_clip_q;
	logic                         o_last_q;

	logic [CNTW-1:0] n;
	logic [31:0]     wprod;
	logic [WW-1:0]   w;
	logic [CNTW:0]   need;
	logic            can_resolve;
	logic [AW-1:0]   off_l;
	logic [AW-1:0]   off_r;
	logic [AW:0]     slot_l;
	logic [AW:0]     slot_r;
	logic [CNTW-1:0] rem_r;

	logic                ring_we;
	logic [AW-1:0]       ring_wa;
	logic [VALUE_BITS:0] ring_wd;
	logic [AW-1:0]       ring_ra;
	logic [1:0]          rd_tag;

	logic                         dv;
	logic signed [VALUE_BITS-1:0] dx;
	logic signed [DFW-1:0]        thr_ext;
	logic signed [DFW-1:0]        dl;
	logic signed [DFW-1:0]        dr;
	logic                         clip_now;
	logic                         div_start;
	logic                         div_done;
	logic [SW-1:0]                div_q;
	logic [SW-1:0]                abs_sum;
	logic [SW-1:0]                res;
	logic                         out_free;

	always_comb begin
		if (column_count == '0) begin
			n = CNTW'(1);
		end else if (32'(column_count) > 32'(MAX_COLUMNS)) begin
			n = CNTW'(MAX_COLUMNS);
		end else begin
			n = CNTW'(column_count);
		end
	end

	assign wprod = 32'(n) * 32'(tsc_pkg::RECIP_MUL);
	assign w     = wprod[tsc_pkg::RECIP_SHIFT +: WW];

	always_comb begin
		need = {1'b0, rsv_q} + ((w != '0) ? (CNTW+1)'(w) - 1'b1 : '0);
		if (need > {1'b0, n - 1'b1}) need = {1'b0, n - 1'b1};
	end
	assign can_resolve = (rsv_q < rcv_q) && ({1'b0, rcv_q} > need);

	// clamped neighbours: offset is min(j, c) to the left, min(j, n-1-c) to the right
	assign rem_r = n - 1'b1 - rsv_q;
	assign off_l = (CNTW'(j_q) > rsv_q) ? AW'(rsv_q) : AW'(j_q);
	assign off_r = (CNTW'(j_q) > rem_r) ? AW'(rem_r) : AW'(j_q);
	always_comb begin
		slot_l = {1'b0, rslot_q} + (AW+1)'(DEPTH) - {1'b0, off_l};
		if (slot_l >= (AW+1)'(DEPTH)) slot_l = slot_l - (AW+1)'(DEPTH);
		slot_r = {1'b0, rslot_q} + {1'b0, off_r};
		if (slot_r >= (AW+1)'(DEPTH)) slot_r = slot_r - (AW+1)'(DEPTH);
	end

	assign dv = rd_data_s1[VALUE_BITS];
	assign dx = rd_data_s1[VALUE_BITS-1:0];

	assign thr_ext  = DFW'(threshold) <<< 8;
	assign dl       = DFW'(v_q) - DFW'(lmin_q);
	assign dr       = DFW'(v_q) - DFW'(rmin_q);
	assign clip_now = cv_q && lhas_q && rhas_q && (dl >= thr_ext) && (dr >= thr_ext);
	assign abs_sum  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign res      = neg_q ? SW'(-div_q) : div_q;
	assign div_start = (state_q == S_EVAL) && clip_now;
	assign out_free = !ov_q || out_ch.ready;
	assign item_pop = (state_q == S_IDLE) && item_avail;

	always_comb begin
		ring_we = 1'b0;
		ring_wa = wslot_q;
		ring_wd = item_data;
		ring_ra = rslot_q;
		rd_tag  = TAG_NONE;
		unique case (state_q)
			S_IDLE: ring_we = item_avail;
			S_CTR: rd_tag = TAG_CTR;
			S_LEFT: begin
				ring_ra = slot_l[AW-1:0];
				rd_tag  = TAG_LEFT;
			end
			S_RIGHT: begin
				ring_ra = slot_r[AW-1:0];
				rd_tag  = TAG_RGHT;
			end
			S_DIV: begin
				ring_we = div_done;
				ring_wa = rslot_q;
				ring_wd = {1'b1, res[VALUE_BITS-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) ring_q[ring_wa] <= ring_wd;
		rd_data_s1 <= ring_q[ring_ra];
	end

	tsc_div #(.NW(SW), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (abs_sum),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// datapath: fold each neighbour read the cycle after it is issued
	always_ff @(posedge clk) begin
		if (state_q == S_CTR) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			lhas_q <= 1'b0;
			rhas_q <= 1'b0;
		end
		case (tag_s1)
			TAG_CTR: begin
				v_q  <= dx;
				cv_q <= dv;
			end
			TAG_LEFT: if (dv) begin
				sum_q <= sum_q + SW'(dx);
				cnt_q <= cnt_q + 1'b1;
				if (!lhas_q || dx < lmin_q) lmin_q <= dx;
				lhas_q <= 1'b1;
			end
			TAG_RGHT: if (dv) begin
				sum_q <= sum_q + SW'(dx);
				cnt_q <= cnt_q + 1'b1;
				if (!rhas_q || dx < rmin_q) rmin_q <= dx;
				rhas_q <= 1'b1;
			end
			default: ;
		endcase
		if (state_q == S_EVAL) begin
			neg_q  <= sum_q[SW-1];
			clip_q <= 1'b0;
		end
		if (state_q == S_DIV && div_done) begin
			v_q    <= res[VALUE_BITS-1:0];
			clip_q <= 1'b1;
		end
		if (state_q == S_OUT && out_free) begin
			o_idx_q  <= tsc_pkg::IDX_W'(rsv_q);
			o_val_q  <= v_q;
			o_vld_q  <= cv_q;
			o_clip_q <= clip_q;
			o_last_q <= (rsv_q == n - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tag_s1  <= TAG_NONE;
			rcv_q   <= '0;
			rsv_q   <= '0;
			wslot_q <= '0;
			rslot_q <= '0;
			j_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			tag_s1 <= rd_tag;
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (item_avail) begin
					rcv_q   <= rcv_q + 1'b1;
					wslot_q <= (wslot_q == AW'(DEPTH - 1)) ? '0 : wslot_q + 1'b1;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (can_resolve) begin
						j_q     <= WW'(1);
						state_q <= S_CTR;
					end else begin
						if (rsv_q >= n) begin
							rcv_q   <= '0;
							rsv_q   <= '0;
							wslot_q <= '0;
							rslot_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_CTR: state_q <= (w > WW'(1)) ? S_LEFT : S_LAST;
				S_LEFT: state_q <= S_RIGHT;
				S_RIGHT: begin
					if ((CW'(j_q) + 1'b1) < CW'(w)) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_LEFT;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: state_q <= S_EVAL;
				S_EVAL: state_q <= clip_now ? S_DIV : S_OUT;
				S_DIV: if (div_done) state_q <= S_OUT;
				S_OUT: if (out_free) begin
					ov_q    <= 1'b1;
					rsv_q   <= rsv_q + 1'b1;
					rslot_q <= (rslot_q == AW'(DEPTH - 1)) ? '0 : rslot_q + 1'b1;
					state_q <= S_CHECK;
				end
				default: state_q <= S_IDLE;
			endcase
			if (restart) begin
				rcv_q   <= '0;
				rsv_q   <= '0;
				wslot_q <= '0;
				rslot_q <= '0;
			end
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.column_index = o_idx_q;
	assign out_ch.value_out    = o_val_q;
	assign out_ch.valid_out    = o_vld_q;
	assign out_ch.clipped      = o_clip_q;
	assign out_ch.last_column  = o_last_q;
endmodule
`default_nettype wire
